### hdl/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cm_pkg
// shared types and constants of the i2c transaction master
// ---------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_WR_NACK  = 2'd1;
  localparam logic [1:0] ST_DAT_NACK = 2'd2;
  localparam logic [1:0] ST_RD_NACK  = 2'd3;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd10;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_TX_LO,
    PH_TX_HI,
    PH_ACKR_LO,
    PH_ACKR_HI,
    PH_RX_LO,
    PH_RX_HI,
    PH_ACKS_LO,
    PH_ACKS_HI,
    PH_STOP_LO,
    PH_STOP_HI,
    PH_STOP_END
  } phase_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       done_res;
    logic [1:0] status;
    logic       busy_res;
  } result_t;

endpackage
`default_nettype wire

### hdl/i2cm_wbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cm_wbuf
// write byte buffer, one write port and one registered read port
// ---------------------------------------------------------------------------
module i2cm_wbuf #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### hdl/i2cm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cm_ctrl
// bus sequencer: line phases, bit and byte counting, buffer access
// ---------------------------------------------------------------------------
module i2cm_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int FW    = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire logic [1:0]       func,
  input  wire logic [6:0]       dev_addr,
  input  wire logic [7:0]       byte_count,
  input  wire logic             sda_level,
  input  wire logic [15:0]      half_period,
  output logic                  mem_we,
  output logic      [AW-1:0]    mem_waddr,
  output logic      [AW-1:0]    mem_raddr,
  input  wire logic [7:0]       mem_rdata,
  output i2cm_pkg::result_t     res
);

  i2cm_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] dc_r, dc_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic        rd_r, rd_nxt;
  logic [1:0]  st_r, st_nxt;

  logic [15:0] hp;
  logic [15:0] dc_inc;
  logic        step;

  assign hp        = (half_period == 16'd0) ? 16'd1 : half_period;
  assign dc_inc    = dc_r + 16'd1;
  assign step      = (dc_inc >= hp) || (dc_inc == 16'd0);
  assign mem_waddr = fill_r[AW-1:0];
  assign mem_raddr = AW'(idx_r);

  always_comb begin
    phase_nxt = phase_r;
    dc_nxt    = dc_r;
    bit_nxt   = bit_r;
    sh_nxt    = sh_r;
    left_nxt  = left_r;
    idx_nxt   = idx_r;
    fill_nxt  = fill_r;
    rd_nxt    = rd_r;
    st_nxt    = st_r;
    mem_we    = 1'b0;
    res       = '0;
    res.scl_level   = 1'b1;
    res.sda_release = 1'b1;
    if (phase_r == i2cm_pkg::PH_IDLE) begin
      if (func == i2cm_pkg::FUNC_LOAD) begin
        if (fill_r < FW'(DEPTH)) begin
          mem_we   = 1'b1;
          fill_nxt = fill_r + FW'(1);
        end
      end else if (func == i2cm_pkg::FUNC_WRITE || func == i2cm_pkg::FUNC_READ) begin
        idx_nxt   = '0;
        phase_nxt = i2cm_pkg::PH_START_A;
        dc_nxt    = '0;
        bit_nxt   = '0;
        if (func == i2cm_pkg::FUNC_READ) begin
          rd_nxt   = 1'b1;
          left_nxt = (byte_count == 8'd0) ? 8'd1 : byte_count;
          sh_nxt   = {dev_addr, 1'b1};
          st_nxt   = i2cm_pkg::ST_RD_NACK;
        end else begin
          rd_nxt   = 1'b0;
          left_nxt = byte_count;
          fill_nxt = '0;
          sh_nxt   = {dev_addr, 1'b0};
          st_nxt   = i2cm_pkg::ST_WR_NACK;
        end
      end
    end else begin
      unique case (phase_r)
        i2cm_pkg::PH_START_B: begin
          res.sda_release = 1'b0;
        end
        i2cm_pkg::PH_TX_LO: begin
          res.scl_level   = 1'b0;
          res.sda_release = sh_r[7];
        end
        i2cm_pkg::PH_TX_HI: begin
          res.sda_release = sh_r[7];
        end
        i2cm_pkg::PH_ACKR_LO, i2cm_pkg::PH_RX_LO: begin
          res.scl_level = 1'b0;
        end
        i2cm_pkg::PH_ACKS_LO: begin
          res.scl_level   = 1'b0;
          res.sda_release = (left_r == 8'd1);
        end
        i2cm_pkg::PH_ACKS_HI: begin
          res.sda_release = (left_r == 8'd1);
        end
        i2cm_pkg::PH_STOP_LO: begin
          res.scl_level   = 1'b0;
          res.sda_release = 1'b0;
        end
        i2cm_pkg::PH_STOP_HI: begin
          res.sda_release = 1'b0;
        end
        default: begin
        end
      endcase
      if (dc_r == 16'd0 &&
          (phase_r == i2cm_pkg::PH_ACKR_HI || phase_r == i2cm_pkg::PH_RX_HI)) begin
        sh_nxt = {sh_r[6:0], sda_level};
      end
      if (!step) begin
        dc_nxt = dc_inc;
      end else begin
        dc_nxt = '0;
        unique case (phase_r)
          i2cm_pkg::PH_START_A: phase_nxt = i2cm_pkg::PH_START_B;
          i2cm_pkg::PH_START_B: phase_nxt = i2cm_pkg::PH_TX_LO;
          i2cm_pkg::PH_TX_LO:   phase_nxt = i2cm_pkg::PH_TX_HI;
          i2cm_pkg::PH_TX_HI: begin
            sh_nxt = {sh_nxt[6:0], 1'b0};
            if (bit_r + 4'd1 >= 4'd8) begin
              bit_nxt   = '0;
              phase_nxt = i2cm_pkg::PH_ACKR_LO;
            end else begin
              bit_nxt   = bit_r + 4'd1;
              phase_nxt = i2cm_pkg::PH_TX_LO;
            end
          end
          i2cm_pkg::PH_ACKR_LO: phase_nxt = i2cm_pkg::PH_ACKR_HI;
          i2cm_pkg::PH_ACKR_HI: begin
            if (sh_nxt[0]) begin
              phase_nxt = i2cm_pkg::PH_STOP_LO;
            end else if (rd_r) begin
              st_nxt    = i2cm_pkg::ST_OK;
              sh_nxt    = '0;
              bit_nxt   = '0;
              phase_nxt = i2cm_pkg::PH_RX_LO;
            end else if (left_r == 8'd0) begin
              st_nxt    = i2cm_pkg::ST_OK;
              phase_nxt = i2cm_pkg::PH_STOP_LO;
            end else begin
              sh_nxt    = mem_rdata;
              idx_nxt   = idx_r + 8'd1;
              left_nxt  = left_r - 8'd1;
              st_nxt    = i2cm_pkg::ST_DAT_NACK;
              bit_nxt   = '0;
              phase_nxt = i2cm_pkg::PH_TX_LO;
            end
          end
          i2cm_pkg::PH_RX_LO: phase_nxt = i2cm_pkg::PH_RX_HI;
          i2cm_pkg::PH_RX_HI: begin
            if (bit_r + 4'd1 >= 4'd8) begin
              bit_nxt      = '0;
              res.rx_byte  = sh_nxt;
              res.rx_valid = 1'b1;
              res.rx_last  = (left_r == 8'd1);
              phase_nxt    = i2cm_pkg::PH_ACKS_LO;
            end else begin
              bit_nxt   = bit_r + 4'd1;
              phase_nxt = i2cm_pkg::PH_RX_LO;
            end
          end
          i2cm_pkg::PH_ACKS_LO: phase_nxt = i2cm_pkg::PH_ACKS_HI;
          i2cm_pkg::PH_ACKS_HI: begin
            if (left_r > 8'd1) begin
              left_nxt  = left_r - 8'd1;
              phase_nxt = i2cm_pkg::PH_RX_LO;
            end else begin
              left_nxt  = '0;
              phase_nxt = i2cm_pkg::PH_STOP_LO;
            end
          end
          i2cm_pkg::PH_STOP_LO: phase_nxt = i2cm_pkg::PH_STOP_HI;
          i2cm_pkg::PH_STOP_HI: phase_nxt = i2cm_pkg::PH_STOP_END;
          i2cm_pkg::PH_STOP_END: begin
            res.done_res = 1'b1;
            res.status   = st_r;
            phase_nxt    = i2cm_pkg::PH_IDLE;
          end
          default: phase_nxt = i2cm_pkg::PH_IDLE;
        endcase
      end
    end
    res.busy_res = (phase_nxt != i2cm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cm_pkg::PH_IDLE;
      dc_r    <= '0;
      bit_r   <= '0;
      sh_r    <= '0;
      left_r  <= '0;
      idx_r   <= '0;
      fill_r  <= '0;
      rd_r    <= 1'b0;
      st_r    <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      dc_r    <= dc_nxt;
      bit_r   <= bit_nxt;
      sh_r    <= sh_nxt;
      left_r  <= left_nxt;
      idx_r   <= idx_nxt;
      fill_r  <= fill_nxt;
      rd_r    <= rd_nxt;
      st_r    <= st_nxt;
    end
  end

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n) bit_r < 4'd8)
    else $error("bit counter out of range");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= FW'(DEPTH))
    else $error("buffer fill beyond depth");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.done_res |=> phase_r == i2cm_pkg::PH_IDLE)
    else $error("done without return to idle");
  a_rx_read: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.rx_valid |-> rd_r)
    else $error("received byte outside a read");

endmodule
`default_nettype wire

### hdl/i2cm_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cm_outq
// two-entry result queue between sequencer and output channel
// ---------------------------------------------------------------------------
module i2cm_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire i2cm_pkg::result_t push_data,
  output logic                   full,
  output logic                   head_valid,
  input  wire logic              pop,
  output i2cm_pkg::result_t      head
);

  i2cm_pkg::result_t q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q0_r;

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    priority if (push && pop) begin
      if (cnt_r == 2'd1) begin
        q0_nxt = push_data;
      end else begin
        q0_nxt = q1_r;
        q1_nxt = push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        q0_nxt = push_data;
      end else begin
        q1_nxt = push_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule
`default_nettype wire

### hdl/i2c_master_transaction_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2c_master_transaction_top
// i2c master running whole write and read transactions from a byte buffer
// ---------------------------------------------------------------------------
// results pass through a registered result queue; buffer reads are registered
// and prefetched. throughput: one item per cycle unless in_stall is high; a
// two-entry result queue keeps input open while one result waits
// reset: synchronous active low, bus idle, half period 10, buffer not cleared
// ---------------------------------------------------------------------------
module i2c_master_transaction_top #(
  parameter int BUF_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [6:0]  in_dev_addr,
  input  wire logic [7:0]  in_byte_count,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_sda_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_scl_level,
  output logic             out_sda_release,
  output logic [7:0]       out_rx_byte,
  output logic             out_rx_valid,
  output logic             out_rx_last,
  output logic             out_done_res,
  output logic [1:0]       out_status,
  output logic             out_busy_res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_half_period
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FW = $clog2(BUF_DEPTH + 1);

  logic [15:0]       half_r;
  logic              acc;
  logic              q_full;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [7:0]        mem_rdata;
  i2cm_pkg::result_t res;
  i2cm_pkg::result_t head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign acc       = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= i2cm_pkg::HALF_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      half_r <= cfg_half_period;
    end
  end

  i2cm_wbuf #(.DEPTH(BUF_DEPTH), .AW(AW)) u_wbuf (
    .clk     (clk),
    .wr_en   (mem_we && acc),
    .wr_addr (mem_waddr),
    .wr_data (in_data_byte),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  i2cm_ctrl #(.DEPTH(BUF_DEPTH), .AW(AW), .FW(FW)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .func        (in_func),
    .dev_addr    (in_dev_addr),
    .byte_count  (in_byte_count),
    .sda_level   (in_sda_level),
    .half_period (half_r),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .res         (res)
  );

  i2cm_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (acc),
    .push_data  (res),
    .full       (q_full),
    .head_valid (out_valid),
    .pop        (out_valid && !out_stall),
    .head       (head)
  );

  assign out_scl_level   = head.scl_level;
  assign out_sda_release = head.sda_release;
  assign out_rx_byte     = head.rx_byte;
  assign out_rx_valid    = head.rx_valid;
  assign out_rx_last     = head.rx_last;
  assign out_done_res    = head.done_res;
  assign out_status      = head.status;
  assign out_busy_res    = head.busy_res;

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the i2c transaction master
// ---------------------------------------------------------------------------
// a generator queues ticks and commands and steers the slave acknowledges
// through a planning copy of the bus line model. a driver offers the queued
// transfers with random gaps. on every accepted transfer a second copy of the
// line model predicts the result, and a monitor compares each delivered
// result field by field under random and long output stalls. the half
// period is changed between phases, from zero up to its largest value.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int BUF_DEPTH  = 256;
  localparam int N_ITEMS    = 1550;
  localparam int PHASE_LEN  = 100;
  localparam int LONG_HOLD  = 80;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] dev_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic       sda_level;
  } bus_item_t;

  typedef struct packed {
    logic [BUF_DEPTH*8-1:0] wbuf;
    i2cm_pkg::phase_t ph;
    logic [15:0] hp;
    logic [15:0] dly;
    logic [3:0]  nbit;
    logic [7:0]  sreg;
    logic [7:0]  left;
    logic [7:0]  bidx;
    logic [8:0]  fill;
    logic [6:0]  addr;
    logic        rd;
    logic [1:0]  st;
  } line_model_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = i2cm_pkg::FUNC_TICK;
  logic [6:0]  in_dev_addr = '0;
  logic [7:0]  in_byte_count = '0;
  logic [7:0]  in_data_byte = '0;
  logic        in_sda_level = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_level;
  logic        out_sda_release;
  logic [7:0]  out_rx_byte;
  logic        out_rx_valid;
  logic        out_rx_last;
  logic        out_done_res;
  logic [1:0]  out_status;
  logic        out_busy_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_half_period = '0;

  i2c_master_transaction_top #(
    .BUF_DEPTH(BUF_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_dev_addr    (in_dev_addr),
    .in_byte_count  (in_byte_count),
    .in_data_byte   (in_data_byte),
    .in_sda_level   (in_sda_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scl_level  (out_scl_level),
    .out_sda_release(out_sda_release),
    .out_rx_byte    (out_rx_byte),
    .out_rx_valid   (out_rx_valid),
    .out_rx_last    (out_rx_last),
    .out_done_res   (out_done_res),
    .out_status     (out_status),
    .out_busy_res   (out_busy_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_half_period(cfg_half_period)
  );

  bus_item_t         pending_xfers [$];
  i2cm_pkg::result_t expected_lines [$];
  line_model_t       bus_pred;
  line_model_t       bus_plan;
  bus_item_t         acc_item;
  bus_item_t         next_item;
  i2cm_pkg::result_t want;
  i2cm_pkg::result_t got;

  int  errors = 0;
  int  n_pushed = 0;
  int  n_results = 0;
  int  n_txn = 0;
  int  n_nack = 0;
  int  n_rxb = 0;
  int  buf_high = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  rx_hold = 0;
  int  hold_reqs = 0;
  int  hold_done = 0;
  bit  idle_en = 1'b1;
  bit  in_fired = 1'b0;

  always #1 clk = ~clk;

  // one tick or command of the bus master, line levels during this tick
  function automatic i2cm_pkg::result_t i2c_line_step(inout line_model_t m,
                                                      input bus_item_t it);
    i2cm_pkg::result_t r;
    logic [15:0]       hp;
    r = '0;
    r.scl_level = 1'b1;
    r.sda_release = 1'b1;
    hp = (m.hp == 16'd0) ? 16'd1 : m.hp;
    if (m.ph == i2cm_pkg::PH_IDLE) begin
      if (it.func == i2cm_pkg::FUNC_LOAD) begin
        if (m.fill < BUF_DEPTH) begin
          m.wbuf[{m.fill[7:0], 3'b000} +: 8] = it.data_byte;
          m.fill = m.fill + 9'd1;
        end
      end else if (it.func == i2cm_pkg::FUNC_WRITE || it.func == i2cm_pkg::FUNC_READ) begin
        m.addr = it.dev_addr;
        m.rd = (it.func == i2cm_pkg::FUNC_READ);
        m.bidx = '0;
        if (m.rd) begin
          m.left = (it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
          m.sreg = {it.dev_addr, 1'b1};
          m.st = i2cm_pkg::ST_RD_NACK;
        end else begin
          m.left = it.byte_count;
          m.fill = '0;
          m.sreg = {it.dev_addr, 1'b0};
          m.st = i2cm_pkg::ST_WR_NACK;
        end
        m.ph = i2cm_pkg::PH_START_A;
        m.dly = '0;
        m.nbit = '0;
      end
    end else begin
      case (m.ph)
        i2cm_pkg::PH_START_B: r.sda_release = 1'b0;
        i2cm_pkg::PH_TX_LO: begin
          r.scl_level = 1'b0;
          r.sda_release = m.sreg[7];
        end
        i2cm_pkg::PH_TX_HI: r.sda_release = m.sreg[7];
        i2cm_pkg::PH_ACKR_LO, i2cm_pkg::PH_RX_LO: r.scl_level = 1'b0;
        i2cm_pkg::PH_ACKS_LO: begin
          r.scl_level = 1'b0;
          r.sda_release = (m.left == 8'd1);
        end
        i2cm_pkg::PH_ACKS_HI: r.sda_release = (m.left == 8'd1);
        i2cm_pkg::PH_STOP_LO: begin
          r.scl_level = 1'b0;
          r.sda_release = 1'b0;
        end
        i2cm_pkg::PH_STOP_HI: r.sda_release = 1'b0;
        default: ;
      endcase
      // sda is sampled on the first tick of a high half
      if (m.dly == 16'd0 && (m.ph == i2cm_pkg::PH_ACKR_HI || m.ph == i2cm_pkg::PH_RX_HI)) begin
        m.sreg = {m.sreg[6:0], it.sda_level};
      end
      m.dly = m.dly + 16'd1;
      if (m.dly >= hp || m.dly == 16'd0) begin
        m.dly = '0;
        case (m.ph)
          i2cm_pkg::PH_START_A: m.ph = i2cm_pkg::PH_START_B;
          i2cm_pkg::PH_START_B: m.ph = i2cm_pkg::PH_TX_LO;
          i2cm_pkg::PH_TX_LO:   m.ph = i2cm_pkg::PH_TX_HI;
          i2cm_pkg::PH_TX_HI: begin
            m.sreg = {m.sreg[6:0], 1'b0};
            m.nbit = m.nbit + 4'd1;
            if (m.nbit >= 4'd8) begin
              m.nbit = '0;
              m.ph = i2cm_pkg::PH_ACKR_LO;
            end else begin
              m.ph = i2cm_pkg::PH_TX_LO;
            end
          end
          i2cm_pkg::PH_ACKR_LO: m.ph = i2cm_pkg::PH_ACKR_HI;
          i2cm_pkg::PH_ACKR_HI: begin
            if (m.sreg[0]) begin
              m.ph = i2cm_pkg::PH_STOP_LO;
            end else if (m.rd) begin
              m.st = i2cm_pkg::ST_OK;
              m.sreg = '0;
              m.nbit = '0;
              m.ph = i2cm_pkg::PH_RX_LO;
            end else if (m.left == 8'd0) begin
              m.st = i2cm_pkg::ST_OK;
              m.ph = i2cm_pkg::PH_STOP_LO;
            end else begin
              m.sreg = m.wbuf[{m.bidx, 3'b000} +: 8];
              m.bidx = m.bidx + 8'd1;
              m.left = m.left - 8'd1;
              m.st = i2cm_pkg::ST_DAT_NACK;
              m.nbit = '0;
              m.ph = i2cm_pkg::PH_TX_LO;
            end
          end
          i2cm_pkg::PH_RX_LO: m.ph = i2cm_pkg::PH_RX_HI;
          i2cm_pkg::PH_RX_HI: begin
            m.nbit = m.nbit + 4'd1;
            if (m.nbit >= 4'd8) begin
              m.nbit = '0;
              r.rx_byte = m.sreg;
              r.rx_valid = 1'b1;
              r.rx_last = (m.left == 8'd1);
              m.ph = i2cm_pkg::PH_ACKS_LO;
            end else begin
              m.ph = i2cm_pkg::PH_RX_LO;
            end
          end
          i2cm_pkg::PH_ACKS_LO: m.ph = i2cm_pkg::PH_ACKS_HI;
          i2cm_pkg::PH_ACKS_HI: begin
            if (m.left > 8'd0) m.left = m.left - 8'd1;
            m.ph = (m.left == 8'd0) ? i2cm_pkg::PH_STOP_LO : i2cm_pkg::PH_RX_LO;
          end
          i2cm_pkg::PH_STOP_LO: m.ph = i2cm_pkg::PH_STOP_HI;
          i2cm_pkg::PH_STOP_HI: m.ph = i2cm_pkg::PH_STOP_END;
          i2cm_pkg::PH_STOP_END: begin
            r.done_res = 1'b1;
            r.status = m.st;
            m.ph = i2cm_pkg::PH_IDLE;
          end
          default: m.ph = i2cm_pkg::PH_IDLE;
        endcase
      end
    end
    r.busy_res = (m.ph != i2cm_pkg::PH_IDLE);
    return r;
  endfunction

  function automatic bus_item_t rand_item(input logic [1:0] fn);
    bus_item_t   it;
    logic [31:0] r;
    r = $urandom;
    it.func = fn;
    it.dev_addr = r[6:0];
    it.byte_count = r[14:7];
    it.data_byte = r[22:15];
    it.sda_level = r[23];
    return it;
  endfunction

  task automatic push_item(input bus_item_t it);
    void'(i2c_line_step(bus_plan, it));
    pending_xfers.push_back(it);
    n_pushed++;
    if (bus_plan.fill > buf_high) buf_high = bus_plan.fill;
  endtask

  task automatic idle_noise(input int n, input int load_pct);
    for (int i = 0; i < n; i++) begin
      push_item(rand_item(($urandom_range(0, 99) < load_pct) ?
                          i2cm_pkg::FUNC_LOAD : i2cm_pkg::FUNC_TICK));
    end
  endtask

  task automatic load_byte(input logic [7:0] d);
    bus_item_t it;
    it = rand_item(i2cm_pkg::FUNC_LOAD);
    it.data_byte = d;
    push_item(it);
  endtask

  task automatic start_xfer(input logic [1:0] fn, input logic [6:0] a, input logic [7:0] n);
    bus_item_t it;
    it = rand_item(fn);
    it.dev_addr = a;
    it.byte_count = n;
    push_item(it);
  endtask

  // ticks until the bus is idle again; the acknowledge numbered nack_at gets a nack
  task automatic finish_xfer(input int nack_at, input int cmd_pct);
    bus_item_t   it;
    logic [31:0] r;
    int          acks;
    acks = 0;
    while (bus_plan.ph != i2cm_pkg::PH_IDLE) begin
      r = $urandom;
      it = rand_item(($urandom_range(0, 99) < cmd_pct) ? r[1:0] : i2cm_pkg::FUNC_TICK);
      if (bus_plan.ph == i2cm_pkg::PH_ACKR_HI && bus_plan.dly == 16'd0) begin
        it.sda_level = (acks == nack_at);
        acks++;
      end
      push_item(it);
    end
  endtask

  task automatic random_xfer();
    logic [31:0] r;
    logic [1:0]  fn;
    int          cnt;
    int          p;
    int          nack;
    r = $urandom;
    idle_noise($urandom_range(0, 5), 60);
    fn = r[0] ? i2cm_pkg::FUNC_READ : i2cm_pkg::FUNC_WRITE;
    p = $urandom_range(0, 19);
    if (p < 12) cnt = $urandom_range(0, 3);
    else if (p < 19) cnt = $urandom_range(4, 8);
    else cnt = $urandom_range(9, 24);
    if (fn == i2cm_pkg::FUNC_WRITE && cnt > buf_high) cnt = buf_high;
    nack = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cnt) : -1;
    start_xfer(fn, r[14:8], cnt[7:0]);
    finish_xfer(nack, 10);
  endtask

  task automatic wait_drained();
    while (n_results != n_pushed) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_half_period(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_half_period <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bus_pred.hp = v;
    bus_plan.hp = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // accepted input transfers and delivered results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      acc_item = {in_func, in_dev_addr, in_byte_count, in_data_byte, in_sda_level};
      expected_lines.push_back(i2c_line_step(bus_pred, acc_item));
      in_fired <= 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = {out_scl_level, out_sda_release, out_rx_byte, out_rx_valid, out_rx_last,
             out_done_res, out_status, out_busy_res};
      if (expected_lines.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got %h", $time, got);
      end else begin
        want = expected_lines.pop_front();
        n_results++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected scl %b sda %b rx %h v %b l %b done %b st %0d busy %b",
                   $time, want.scl_level, want.sda_release, want.rx_byte, want.rx_valid,
                   want.rx_last, want.done_res, want.status, want.busy_res);
          $display("%0t:          actual   scl %b sda %b rx %h v %b l %b done %b st %0d busy %b",
                   $time, got.scl_level, got.sda_release, got.rx_byte, got.rx_valid,
                   got.rx_last, got.done_res, got.status, got.busy_res);
        end
        if (want.done_res) n_txn++;
        if (want.done_res && want.status != i2cm_pkg::ST_OK) n_nack++;
        if (want.rx_valid) n_rxb++;
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fired)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_xfers.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        tx_gap = $urandom_range(0, 17);
        in_valid <= 1'b0;
      end else begin
        next_item = pending_xfers.pop_front();
        {in_func, in_dev_addr, in_byte_count, in_data_byte, in_sda_level} <= next_item;
        in_valid <= 1'b1;
      end
    end
    in_fired <= 1'b0;
  end

  // output stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_done != hold_reqs) begin
      hold_done = hold_reqs;
      rx_hold = LONG_HOLD;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 15) == 0) begin
      rx_gap = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int          ph_i;
    int          ph_start;
    bit          tail_part;
    logic [15:0] hp_v;
    logic [31:0] r;
    bus_pred = '0;
    bus_pred.hp = i2cm_pkg::HALF_PERIOD_RST;
    bus_plan = bus_pred;
    ph_i = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed: reset half period, field extremes, every nack kind
    idle_noise(2, 0);
    load_byte(8'h00);
    load_byte(8'hFF);
    load_byte(8'hA5);
    start_xfer(i2cm_pkg::FUNC_WRITE, 7'h00, 8'd0);
    finish_xfer(-1, 0);
    wait_drained();
    set_half_period(16'd0);
    start_xfer(i2cm_pkg::FUNC_WRITE, 7'h7F, 8'd3);
    finish_xfer(-1, 0);
    load_byte(8'h5A);
    load_byte(8'h3C);
    start_xfer(i2cm_pkg::FUNC_WRITE, 7'h2A, 8'd2);
    finish_xfer(1, 50);
    start_xfer(i2cm_pkg::FUNC_WRITE, 7'h11, 8'd2);
    finish_xfer(0, 0);
    start_xfer(i2cm_pkg::FUNC_READ, 7'h55, 8'd0);
    finish_xfer(-1, 0);
    start_xfer(i2cm_pkg::FUNC_READ, 7'h7F, 8'd255);
    finish_xfer(0, 0);
    start_xfer(i2cm_pkg::FUNC_READ, 7'h00, 8'd3);
    finish_xfer(-1, 0);
    wait_drained();

    // random: fill the buffer past full, then phases of transactions
    set_half_period(16'd1);
    repeat (BUF_DEPTH + 4) begin
      r = $urandom;
      load_byte(r[7:0]);
    end
    wait_drained();
    while (n_pushed < N_ITEMS) begin
      tail_part = n_pushed > (N_ITEMS * 85 / 100);
      case (ph_i % 8)
        0: hp_v = 16'd1;
        1: hp_v = 16'hFFFF;
        2: hp_v = 16'd2;
        3: hp_v = 16'd3;
        4: hp_v = 16'd0;
        5: hp_v = 16'd4;
        6: hp_v = 16'd7;
        default: hp_v = 16'd1;
      endcase
      if (tail_part) hp_v = 16'd1;
      idle_en = !tail_part && ($urandom_range(0, 3) != 0);
      set_half_period(hp_v);
      if (hp_v == 16'hFFFF) begin
        // slowest timing: a transfer starts, then the period is shortened
        r = $urandom;
        idle_noise(20, 50);
        start_xfer(i2cm_pkg::FUNC_WRITE, r[6:0], 8'd1);
        repeat (30) push_item(rand_item(i2cm_pkg::FUNC_TICK));
        wait_drained();
        set_half_period(16'd2);
        finish_xfer(-1, 10);
      end else begin
        ph_start = n_pushed;
        while (n_pushed - ph_start < PHASE_LEN) random_xfer();
        if (ph_i == 2) hold_reqs++;
      end
      wait_drained();
      ph_i++;
    end

    repeat (10) @(negedge clk);
    if (expected_lines.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_lines.size());
    end
    $display("summary: %0d transfers checked, %0d transactions ended, %0d nacked, %0d bytes read",
             n_results, n_txn, n_nack, n_rxb);
    $display("summary: half periods 0 to 65535, buffer filled past full, commands while busy");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d of %0d results seen", $time, n_results, n_pushed);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
